// File: rtl/temna_pkg.sv
// Shared types and constants for the tet4-to-tet10 midside node allocator.
// Holds the microcode format, the microcode ROM and the edge walk order.
// No dependencies.
package temna_pkg;

	// Widths fixed by the interface
	localparam int ID_W          = 12;
	localparam int CID_W         = 7;
	localparam int EDGES_PER_TET = 6;
	localparam int EDGE_W        = 3;

	localparam logic [CID_W-1:0] NODE_COUNT_RST = 7'd64;

	// Request and result kinds
	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_ELEM  = 1'b1;
	localparam logic KIND_NODE = 1'b0;
	localparam logic KIND_ELEM = 1'b1;

	// Edge walk order over corners a=0, b=1, c=2, d=3: ab, bc, ac, ad, cd, bd
	localparam logic [1:0] EDGE_P [EDGES_PER_TET] = '{2'd0, 2'd1, 2'd0, 2'd0, 2'd2, 2'd1};
	localparam logic [1:0] EDGE_Q [EDGES_PER_TET] = '{2'd1, 2'd2, 2'd2, 2'd3, 2'd3, 2'd3};

	// Edge table entry
	typedef struct packed {
		logic            valid;
		logic [ID_W-1:0] id;
	} tbl_entry_t;

	// Microcode
	localparam int UC_LEN  = 19;
	localparam int UC_PC_W = 5;

	typedef enum logic [1:0] {
		OP_LOOKUP,   // present slot address, wait for registered read
		OP_RESOLVE,  // hit: take stored id and jump; miss: fall through
		OP_NEW,      // allocate id, write table, emit midpoint
		OP_EMIT      // emit element edge id list, end of program
	} op_t;

	typedef struct packed {
		op_t                op;
		logic [EDGE_W-1:0]  edge_sel;
		logic [UC_PC_W-1:0] target;
	} ucode_t;

	function automatic ucode_t uc_rom(input logic [UC_PC_W-1:0] pc);
		ucode_t w;
		w = '{op: OP_EMIT, edge_sel: 3'd0, target: 5'd0};
		case (pc)
			5'd0:  w = '{op: OP_LOOKUP,  edge_sel: 3'd0, target: 5'd0};
			5'd1:  w = '{op: OP_RESOLVE, edge_sel: 3'd0, target: 5'd3};
			5'd2:  w = '{op: OP_NEW,     edge_sel: 3'd0, target: 5'd0};
			5'd3:  w = '{op: OP_LOOKUP,  edge_sel: 3'd1, target: 5'd0};
			5'd4:  w = '{op: OP_RESOLVE, edge_sel: 3'd1, target: 5'd6};
			5'd5:  w = '{op: OP_NEW,     edge_sel: 3'd1, target: 5'd0};
			5'd6:  w = '{op: OP_LOOKUP,  edge_sel: 3'd2, target: 5'd0};
			5'd7:  w = '{op: OP_RESOLVE, edge_sel: 3'd2, target: 5'd9};
			5'd8:  w = '{op: OP_NEW,     edge_sel: 3'd2, target: 5'd0};
			5'd9:  w = '{op: OP_LOOKUP,  edge_sel: 3'd3, target: 5'd0};
			5'd10: w = '{op: OP_RESOLVE, edge_sel: 3'd3, target: 5'd12};
			5'd11: w = '{op: OP_NEW,     edge_sel: 3'd3, target: 5'd0};
			5'd12: w = '{op: OP_LOOKUP,  edge_sel: 3'd4, target: 5'd0};
			5'd13: w = '{op: OP_RESOLVE, edge_sel: 3'd4, target: 5'd15};
			5'd14: w = '{op: OP_NEW,     edge_sel: 3'd4, target: 5'd0};
			5'd15: w = '{op: OP_LOOKUP,  edge_sel: 3'd5, target: 5'd0};
			5'd16: w = '{op: OP_RESOLVE, edge_sel: 3'd5, target: 5'd18};
			5'd17: w = '{op: OP_NEW,     edge_sel: 3'd5, target: 5'd0};
			5'd18: w = '{op: OP_EMIT,    edge_sel: 3'd0, target: 5'd0};
			default: w = '{op: OP_EMIT,  edge_sel: 3'd0, target: 5'd0};
		endcase
		return w;
	endfunction

endpackage

// File: rtl/temna_edge_table.sv
// Edge table: single-port memory of valid bit plus midpoint id per corner pair.
// Runs a clearing pass over every entry after reset. Depends on temna_pkg.
module temna_edge_table import temna_pkg::*; #(
	parameter int DEPTH  = 4096,
	parameter int ADDR_W = 12
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [ADDR_W-1:0] addr,
	input  logic              we,
	input  tbl_entry_t        wdata,
	output tbl_entry_t        rdata,
	output logic              clearing
);

	tbl_entry_t        mem [DEPTH];
	logic [ADDR_W-1:0] clr_q;
	logic              clearing_q;
	logic [ADDR_W-1:0] mem_addr;
	logic              mem_we;
	tbl_entry_t        mem_wdata;

	// clearing pass owns the port until done
	always_comb begin
		mem_addr  = clearing_q ? clr_q : addr;
		mem_we    = clearing_q | we;
		mem_wdata = clearing_q ? tbl_entry_t'('0) : wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= '0;
			clearing_q <= 1'b1;
		end else if (clearing_q) begin
			clr_q <= clr_q + 1'b1;
			if (clr_q == ADDR_W'(DEPTH - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// memory: single port, a write plus a registered read at the same address
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
		rdata <= mem[mem_addr];
	end

	assign clearing = clearing_q;

endmodule

// File: rtl/tet_edge_midpoint_node_allocator.sv
// Top level of the tet4-to-tet10 midside node allocator: microcoded sequencer,
// corner coordinate memory and output register. Depends on temna_pkg and
// temna_edge_table.
//
// After reset the edge table is swept clear, all MAX_NODES*MAX_NODES entries
// (4096 at the default), while in_ready stays low; configuration writes are
// taken during that time. A load request returns nothing and sets no busy state.
// A tetrahedron request runs a 19-step microprogram over the six edges: an
// edge already in the table takes lookup and resolve, a new edge takes lookup,
// resolve and allocate, and the element result comes last; the element holds
// the request port from its acceptance until that result is taken into the
// output register. The step sequence is set by the single port of the edge
// table, which serves one address per cycle. Results leave through a one-deep
// output register, so lookups go on while the previous result waits to be
// taken; allocate and result steps wait until the register is free.
module tet_edge_midpoint_node_allocator import temna_pkg::*; #(
	parameter int MAX_NODES  = 64,
	parameter int COORD_BITS = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// configuration
	input  logic                         cfg_we,
	input  logic [CID_W-1:0]             cfg_wdata,
	// request channel
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         req_type,
	input  logic [CID_W-1:0]             node_index,
	input  logic signed [COORD_BITS-1:0] coord_x,
	input  logic signed [COORD_BITS-1:0] coord_y,
	input  logic signed [COORD_BITS-1:0] coord_z,
	input  logic [CID_W-1:0]             corner_a,
	input  logic [CID_W-1:0]             corner_b,
	input  logic [CID_W-1:0]             corner_c,
	input  logic [CID_W-1:0]             corner_d,
	// result channel
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         result_kind,
	output logic [ID_W-1:0]              new_node_id,
	output logic signed [COORD_BITS-1:0] mid_x,
	output logic signed [COORD_BITS-1:0] mid_y,
	output logic signed [COORD_BITS-1:0] mid_z,
	output logic [ID_W-1:0]              edge_ab_id,
	output logic [ID_W-1:0]              edge_bc_id,
	output logic [ID_W-1:0]              edge_ac_id,
	output logic [ID_W-1:0]              edge_ad_id,
	output logic [ID_W-1:0]              edge_cd_id,
	output logic [ID_W-1:0]              edge_bd_id,
	output logic                         last
);

	localparam int IDX_W     = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int TBL_DEPTH = MAX_NODES * MAX_NODES;
	localparam int SLOT_W    = $clog2(TBL_DEPTH);
	localparam int CW        = COORD_BITS;

	// configuration and control state
	logic [CID_W-1:0]   node_count_q;
	logic [ID_W-1:0]    edges_made_q;
	logic [UC_PC_W-1:0] pc_q;
	logic               busy_q;
	logic               out_valid_q;

	// payload state
	logic [IDX_W-1:0]   corner_q [4];
	logic [ID_W-1:0]    ids_q [EDGES_PER_TET];
	logic [3*CW-1:0]    corner_mem [MAX_NODES];
	logic [3*CW-1:0]    lo_rd_q;
	logic [3*CW-1:0]    hi_rd_q;

	logic               result_kind_q;
	logic [ID_W-1:0]    new_node_id_q;
	logic [CW-1:0]      mid_x_q, mid_y_q, mid_z_q;
	logic [ID_W-1:0]    edge_id_q [EDGES_PER_TET];
	logic               last_q;

	// datapath signals
	ucode_t             uc;
	logic               in_acc;
	logic               load_acc;
	logic               elem_acc;
	logic               out_free;
	logic [IDX_W-1:0]   p_idx, q_idx, lo_idx, hi_idx;
	logic [SLOT_W-1:0]  slot;
	logic [ID_W-1:0]    alloc_id;
	logic               tbl_we;
	tbl_entry_t         tbl_wdata;
	tbl_entry_t         tbl_rdata;
	logic               tbl_clearing;
	logic               do_new;
	logic               do_emit;
	logic [CW-1:0]      mid_xc, mid_yc, mid_zc;
	logic [IDX_W-1:0]   sat_idx [4];
	logic [CID_W-1:0]   cin [4];

	// saturate a one-based corner id to a zero-based index
	function automatic logic [IDX_W-1:0] corner_sat(input logic [CID_W-1:0] id);
		logic [IDX_W-1:0] r;
		if (id == '0) begin
			r = '0;
		end else if (32'(id) > MAX_NODES) begin
			r = IDX_W'(MAX_NODES - 1);
		end else begin
			r = IDX_W'(CID_W'(id - 1'b1));
		end
		return r;
	endfunction

	// floor of half the sign-extended sum
	function automatic logic [CW-1:0] mid_of(input logic [CW-1:0] a, input logic [CW-1:0] b);
		logic [CW:0] s;
		s = {a[CW-1], a} + {b[CW-1], b};
		return s[CW:1];
	endfunction

	// handshakes
	assign in_ready = !busy_q && !tbl_clearing;
	assign in_acc   = in_valid && in_ready;
	assign load_acc = in_acc && (req_type == REQ_LOAD);
	assign elem_acc = in_acc && (req_type == REQ_ELEM);
	assign out_free = !out_valid_q || out_ready;

	// current control word
	assign uc = uc_rom(pc_q);

	// corner pair of the current edge, ordered, and its table slot
	always_comb begin
		p_idx  = corner_q[EDGE_P[uc.edge_sel]];
		q_idx  = corner_q[EDGE_Q[uc.edge_sel]];
		lo_idx = (p_idx < q_idx) ? p_idx : q_idx;
		hi_idx = (p_idx < q_idx) ? q_idx : p_idx;
		slot   = SLOT_W'(lo_idx) * SLOT_W'(MAX_NODES) + SLOT_W'(hi_idx);
	end

	// next midpoint id and step enables
	assign alloc_id  = ID_W'(node_count_q) + ID_W'(1) + edges_made_q;
	assign do_new    = busy_q && (uc.op == OP_NEW) && out_free;
	assign do_emit   = busy_q && (uc.op == OP_EMIT) && out_free;
	assign tbl_we    = do_new;
	assign tbl_wdata = '{valid: 1'b1, id: alloc_id};

	// midpoints from the registered corner reads
	assign mid_xc = mid_of(lo_rd_q[CW-1:0],      hi_rd_q[CW-1:0]);
	assign mid_yc = mid_of(lo_rd_q[2*CW-1:CW],   hi_rd_q[2*CW-1:CW]);
	assign mid_zc = mid_of(lo_rd_q[3*CW-1:2*CW], hi_rd_q[3*CW-1:2*CW]);

	// saturated corner indices of the incoming request
	always_comb begin
		cin[0] = corner_a;
		cin[1] = corner_b;
		cin[2] = corner_c;
		cin[3] = corner_d;
		for (int i = 0; i < 4; i++) begin
			sat_idx[i] = corner_sat(cin[i]);
		end
	end

	temna_edge_table #(
		.DEPTH  (TBL_DEPTH),
		.ADDR_W (SLOT_W)
	) u_edge_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.addr     (slot),
		.we       (tbl_we),
		.wdata    (tbl_wdata),
		.rdata    (tbl_rdata),
		.clearing (tbl_clearing)
	);

	// sequencer, counters and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= NODE_COUNT_RST;
			edges_made_q <= '0;
			pc_q         <= '0;
			busy_q       <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				node_count_q <= cfg_wdata;
			end
			if (do_new || do_emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (elem_acc) begin
				busy_q <= 1'b1;
				pc_q   <= '0;
			end else if (busy_q) begin
				case (uc.op)
					OP_LOOKUP: begin
						pc_q <= pc_q + 1'b1;
					end
					OP_RESOLVE: begin
						pc_q <= tbl_rdata.valid ? uc.target : pc_q + 1'b1;
					end
					OP_NEW: begin
						if (out_free) begin
							edges_made_q <= edges_made_q + 1'b1;
							pc_q         <= pc_q + 1'b1;
						end
					end
					OP_EMIT: begin
						if (out_free) begin
							busy_q <= 1'b0;
							pc_q   <= '0;
						end
					end
					default: begin
						busy_q <= 1'b0;
					end
				endcase
			end
		end
	end

	// corner registers and edge ids
	always_ff @(posedge clk) begin
		if (elem_acc) begin
			for (int i = 0; i < 4; i++) begin
				corner_q[i] <= sat_idx[i];
			end
		end
		if (busy_q && (uc.op == OP_RESOLVE) && tbl_rdata.valid) begin
			ids_q[uc.edge_sel] <= tbl_rdata.id;
		end else if (do_new) begin
			ids_q[uc.edge_sel] <= alloc_id;
		end
	end

	// corner coordinate memory: one write, two registered reads
	always_ff @(posedge clk) begin
		if (load_acc && (node_index != '0) && (32'(node_index) <= MAX_NODES)) begin
			corner_mem[IDX_W'(CID_W'(node_index - 1'b1))] <= {coord_z, coord_y, coord_x};
		end
		lo_rd_q <= corner_mem[lo_idx];
		hi_rd_q <= corner_mem[hi_idx];
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (do_new) begin
			result_kind_q <= KIND_NODE;
			new_node_id_q <= alloc_id;
			mid_x_q       <= mid_xc;
			mid_y_q       <= mid_yc;
			mid_z_q       <= mid_zc;
			for (int i = 0; i < EDGES_PER_TET; i++) begin
				edge_id_q[i] <= '0;
			end
			last_q        <= 1'b0;
		end else if (do_emit) begin
			result_kind_q <= KIND_ELEM;
			new_node_id_q <= '0;
			mid_x_q       <= '0;
			mid_y_q       <= '0;
			mid_z_q       <= '0;
			for (int i = 0; i < EDGES_PER_TET; i++) begin
				edge_id_q[i] <= ids_q[i];
			end
			last_q        <= 1'b1;
		end
	end

	assign out_valid   = out_valid_q;
	assign result_kind = result_kind_q;
	assign new_node_id = new_node_id_q;
	assign mid_x       = mid_x_q;
	assign mid_y       = mid_y_q;
	assign mid_z       = mid_z_q;
	assign edge_ab_id  = edge_id_q[0];
	assign edge_bc_id  = edge_id_q[1];
	assign edge_ac_id  = edge_id_q[2];
	assign edge_ad_id  = edge_id_q[3];
	assign edge_cd_id  = edge_id_q[4];
	assign edge_bd_id  = edge_id_q[5];
	assign last        = last_q;

	// no table write may collide with the clearing pass
	a_no_write_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		tbl_we |-> !tbl_clearing)
		else $error("edge table written during clearing pass");

	// each allocation bumps the edge counter by one
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		tbl_we |=> (edges_made_q == $past(edges_made_q) + 1'b1))
		else $error("edge counter out of step with allocations");

	// element results always close the request
	a_elem_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (result_kind == KIND_ELEM)) |-> last)
		else $error("element result without last");

	// program counter stays inside the microprogram
	a_pc_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (32'(pc_q) < UC_LEN))
		else $error("microprogram counter out of range");

endmodule
